// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checked at every clock edge while reset is released.
`define ASSERT_RST(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
	else $error("assertion failed: %m");

// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
	else $error("assertion failed: %m");

`else

`define ASSERT_RST(lbl, clk, rstn, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== hw/rtl/rtd_pkg.sv =====
// ----------------------------------------------------------------------------
// rtd_pkg
// Types and constants of the ring termination detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rtd_pkg;

	localparam int AGENT_W            = 4;
	localparam int AGENT_SPAN         = 16;
	localparam int CFG_W              = 5;
	localparam int MAX_AGENTS_DEFAULT = 16;

	localparam logic [CFG_W-1:0]   ACTIVE_RESET = CFG_W'(16);
	localparam logic [AGENT_W-1:0] MASTER_AGENT = '0;

	typedef struct packed {
		logic [AGENT_W-1:0] agent;
		logic               work_happened;
	} item_t;

	typedef struct packed {
		logic               terminated;
		logic               token_passed;
		logic [AGENT_W-1:0] token_receiver;
		logic               token_black;
		logic               error;
	} result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rtd_core.sv =====
// ----------------------------------------------------------------------------
// rtd_core
// Token ring state and the update for one agent report, applied on each step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rtd_core #(
	parameter int MAX_AGENTS = rtd_pkg::MAX_AGENTS_DEFAULT
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            step,
	input  wire rtd_pkg::item_t            item,
	input  wire [rtd_pkg::CFG_W-1:0]       active_agents,
	output rtd_pkg::result_t               res
);

	localparam int LIMIT = (MAX_AGENTS < rtd_pkg::AGENT_SPAN) ? MAX_AGENTS
	                                                          : rtd_pkg::AGENT_SPAN;
	localparam int IDX_W = $clog2(LIMIT);
	localparam logic [rtd_pkg::CFG_W-1:0]   LIMIT_C   = rtd_pkg::CFG_W'(LIMIT);

	// Only the holder's token color matters, so the token is kept as a
	// position and one color bit rather than per-agent flags.
	logic [LIMIT-1:0]             agent_black_q, agent_black_d;
	logic [rtd_pkg::AGENT_W-1:0]  token_pos_q, token_pos_d;
	logic                         token_black_q, token_black_d;
	logic                         last_white_q, last_white_d;
	logic                         done_q, done_d;

	logic [rtd_pkg::CFG_W-1:0]    ring_n;
	logic [rtd_pkg::CFG_W-1:0]    agent_ext;
	logic [rtd_pkg::CFG_W-1:0]    next_agent;
	logic [rtd_pkg::AGENT_W-1:0]  receiver;
	logic [IDX_W-1:0]             idx;
	logic                         reject, holds, is_master, agent_black, failed;
	logic                         keep, pass, black;

	always_comb begin
		if (active_agents == '0) begin
			ring_n = rtd_pkg::CFG_W'(1);
		end else if (active_agents > LIMIT_C) begin
			ring_n = LIMIT_C;
		end else begin
			ring_n = active_agents;
		end
	end

	assign agent_ext   = {1'b0, item.agent};
	assign next_agent  = agent_ext + rtd_pkg::CFG_W'(1);
	assign receiver    = (next_agent == ring_n) ? rtd_pkg::MASTER_AGENT
	                                            : next_agent[rtd_pkg::AGENT_W-1:0];
	assign reject      = (agent_ext >= ring_n) || (item.work_happened && done_q);
	assign idx         = item.agent[IDX_W-1:0];
	assign holds       = (token_pos_q == item.agent);
	assign is_master   = (item.agent == rtd_pkg::MASTER_AGENT);
	assign agent_black = agent_black_q[idx] | item.work_happened;
	assign failed      = token_black_q | agent_black;
	assign keep        = holds && is_master && last_white_q && !failed;
	assign pass        = holds && !keep;
	// The master clears both marks before sending, so its token goes out white.
	assign black       = is_master ? 1'b0 : failed;

	always_comb begin
		agent_black_d = agent_black_q;
		token_pos_d   = token_pos_q;
		token_black_d = token_black_q;
		last_white_d  = last_white_q;
		done_d        = done_q;
		if (!reject) begin
			agent_black_d[idx] = holds ? 1'b0 : agent_black;
			if (holds) begin
				token_black_d = pass ? black : 1'b0;
				if (pass) begin
					token_pos_d = receiver;
				end
				if (is_master) begin
					last_white_d = !failed;
					done_d       = done_q | keep;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			agent_black_q <= '1;
			token_pos_q   <= rtd_pkg::MASTER_AGENT;
			token_black_q <= 1'b0;
			last_white_q  <= 1'b1;
			done_q        <= 1'b0;
		end else if (step) begin
			agent_black_q <= agent_black_d;
			token_pos_q   <= token_pos_d;
			token_black_q <= token_black_d;
			last_white_q  <= last_white_d;
			done_q        <= done_d;
		end
	end

	always_comb begin
		res.terminated     = done_d;
		res.token_passed   = !reject && pass;
		res.token_receiver = (!reject && pass) ? receiver : rtd_pkg::MASTER_AGENT;
		res.token_black    = !reject && pass && black;
		res.error          = reject;
	end

	`ASSERT_RST(a_done_sticks, clk, arst_n, done_q |=> done_q)
	`ASSERT_RST(a_reject_holds_state, clk, arst_n,
		(step && reject) |=> ($stable(agent_black_q) && $stable(token_pos_q)))
	`ASSERT_RST(a_token_in_ring, clk, arst_n, rtd_pkg::CFG_W'(token_pos_q) < LIMIT_C)
	`ASSERT_RST(a_done_keeps_token, clk, arst_n,
		done_q |-> (token_pos_q == rtd_pkg::MASTER_AGENT))

endmodule

`default_nettype wire

// ===== hw/rtl/ring_termination_detector.sv =====
// An accepted word waits in the input register; its result word is then held
// in the result register. Throughput: one report per cycle unless out_stall
// holds the result register; the token state updates as the word moves on.
// Reset: asynchronous, active low; the master holds a white token, all agents
// are black, the ring size is 16 and no words are pending.
// ----------------------------------------------------------------------------
// ring_termination_detector
// Colored-token termination detection over a ring of worker agents.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ring_termination_detector #(
	parameter int MAX_AGENTS = rtd_pkg::MAX_AGENTS_DEFAULT
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire [rtd_pkg::CFG_W-1:0]         cfg_wdata,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire [rtd_pkg::AGENT_W-1:0]       agent,
	input  wire                              work_happened,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic                             terminated,
	output logic                             token_passed,
	output logic [rtd_pkg::AGENT_W-1:0]      token_receiver,
	output logic                             token_black,
	output logic                             error
);

	logic [rtd_pkg::CFG_W-1:0] active_agents_q;
	logic                      valid_s1, valid_s2;
	rtd_pkg::item_t            item_s1;
	rtd_pkg::result_t          res, res_s2;
	logic                      advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_agents_q <= rtd_pkg::ACTIVE_RESET;
		end else if (cfg_we) begin
			active_agents_q <= cfg_wdata;
		end
	end

	// A word leaves the input register when the result register is free or
	// its word is being taken in the same cycle.
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.agent         <= agent;
			item_s1.work_happened <= work_happened;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	rtd_core #(
		.MAX_AGENTS(MAX_AGENTS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.item         (item_s1),
		.active_agents(active_agents_q),
		.res          (res)
	);

	assign out_valid      = valid_s2;
	assign terminated     = res_s2.terminated;
	assign token_passed   = res_s2.token_passed;
	assign token_receiver = res_s2.token_receiver;
	assign token_black    = res_s2.token_black;
	assign error          = res_s2.error;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ring termination detector. Token-ring reports
// are sent one word at a time and every result word is compared against a
// cycle-free model of the token, the agent colors and the termination flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 3000;
	localparam int PHASE_ITEMS  = 160;

	logic                          clk           = 1'b0;
	logic                          arst_n        = 1'b0;
	logic                          cfg_we        = 1'b0;
	logic [rtd_pkg::CFG_W-1:0]     cfg_wdata     = '0;
	logic                          in_valid      = 1'b0;
	logic                          in_stall;
	logic [rtd_pkg::AGENT_W-1:0]   agent         = '0;
	logic                          work_happened = 1'b0;
	logic                          out_valid;
	logic                          out_stall     = 1'b0;
	logic                          terminated;
	logic                          token_passed;
	logic [rtd_pkg::AGENT_W-1:0]   token_receiver;
	logic                          token_black;
	logic                          error;

	// Model of the ring as seen after every accepted report.
	logic                          tok_held [rtd_pkg::AGENT_SPAN];
	logic                          tok_dirty [rtd_pkg::AGENT_SPAN];
	logic                          agent_dirty [rtd_pkg::AGENT_SPAN];
	logic                          prev_round_clean;
	logic                          ring_done;
	logic [rtd_pkg::CFG_W-1:0]     ring_size_reg;

	rtd_pkg::result_t              pending_outcomes [$];
	int                            errors_seen = 0;
	int                            quiet_cycles = 0;
	bit                            no_idle = 1'b0;
	bit                            hold_req = 1'b0;
	bit                            hold_taken = 1'b0;

	ring_termination_detector u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.agent          (agent),
		.work_happened  (work_happened),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.terminated     (terminated),
		.token_passed   (token_passed),
		.token_receiver (token_receiver),
		.token_black    (token_black),
		.error          (error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int ring_of(input logic [rtd_pkg::CFG_W-1:0] v);
		int n;
		n = int'(v);
		if (n < 1) n = 1;
		if (n > rtd_pkg::AGENT_SPAN) n = rtd_pkg::AGENT_SPAN;
		return n;
	endfunction

	function automatic int holder_idx();
		int h;
		h = 0;
		for (int i = 0; i < rtd_pkg::AGENT_SPAN; i++)
			if (tok_held[i]) h = i;
		return h;
	endfunction

	// True when an idle report from the master would end the detection.
	function automatic bit master_would_finish();
		return tok_held[0] && prev_round_clean && !tok_dirty[0] && !agent_dirty[0];
	endfunction

	function automatic rtd_pkg::result_t step_ring(input logic [rtd_pkg::AGENT_W-1:0] a,
	                                                 input logic w);
		rtd_pkg::result_t r;
		int      n;
		int      nxt;
		logic    failed;
		logic    keep;
		logic    blk;
		r = '0;
		n = ring_of(ring_size_reg);
		if (int'(a) >= n || (w && ring_done)) begin
			r.error = 1'b1;
		end else begin
			if (w) agent_dirty[a] = 1'b1;
			if (tok_held[a]) begin
				keep = 1'b0;
				if (a == rtd_pkg::MASTER_AGENT) begin
					failed = tok_dirty[0] | agent_dirty[0];
					tok_dirty[0] = 1'b0;
					agent_dirty[0] = 1'b0;
					if (prev_round_clean && !failed) begin
						ring_done = 1'b1;
						keep = 1'b1;
					end else begin
						prev_round_clean = !failed;
					end
				end
				if (!keep) begin
					blk = tok_dirty[a] | agent_dirty[a];
					tok_dirty[a] = 1'b0;
					agent_dirty[a] = 1'b0;
					tok_held[a] = 1'b0;
					nxt = (int'(a) + 1) % n;
					tok_dirty[nxt] = blk;
					tok_held[nxt] = 1'b1;
					r.token_passed = 1'b1;
					r.token_receiver = rtd_pkg::AGENT_W'(nxt);
					r.token_black = blk;
				end
			end
		end
		r.terminated = ring_done;
		return r;
	endfunction

	// Offers one report and returns at the edge where it was accepted.
	// Valid is left high so that a following report can go out back to back.
	task automatic send_report(input logic [rtd_pkg::AGENT_W-1:0] a, input logic w);
		int gap;
		gap = 0;
		if (!no_idle)
			while ($urandom_range(99) < 33) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		agent <= a;
		work_happened <= w;
		do @(posedge clk); while (in_stall);
		pending_outcomes.push_back(step_ring(a, w));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_ring(input logic [rtd_pkg::CFG_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		ring_size_reg = v;
	endtask

	task automatic noise_report();
		logic [rtd_pkg::AGENT_W-1:0] a;
		logic                        w;
		a = rtd_pkg::AGENT_W'($urandom_range(rtd_pkg::AGENT_SPAN - 1));
		w = 1'($urandom_range(1));
		if (a == rtd_pkg::MASTER_AGENT && master_would_finish()) w = 1'b1;
		send_report(a, w);
	endtask

	// Switches the ring size. If the token sits beyond the new size, the stuck
	// ring is exercised briefly, then the token is walked back into range.
	task automatic enter_ring(input logic [rtd_pkg::CFG_W-1:0] v);
		set_ring(v);
		if (holder_idx() >= ring_of(v)) begin
			repeat (6) noise_report();
			set_ring(rtd_pkg::CFG_W'(rtd_pkg::AGENT_SPAN));
			while (holder_idx() >= ring_of(v))
				send_report(rtd_pkg::AGENT_W'(holder_idx()), 1'b1);
			set_ring(v);
		end
	endtask

	// Mostly the token holder reports, with random work; the rest is noise
	// from any agent. The master never sees a finishing round here.
	task automatic random_reports(input int count);
		int                          h;
		logic [rtd_pkg::AGENT_W-1:0] a;
		logic                        w;
		for (int i = 0; i < count; i++) begin
			h = holder_idx();
			if ($urandom_range(99) < 75 && h < ring_of(ring_size_reg)) begin
				a = rtd_pkg::AGENT_W'(h);
				w = ($urandom_range(99) < 30);
				if (a == rtd_pkg::MASTER_AGENT && master_would_finish()) w = 1'b1;
				send_report(a, w);
			end else begin
				noise_report();
			end
		end
	endtask

	task automatic test_directed_edges();
		send_report(4'd15, 1'b1);
		send_report(4'd0, 1'b0);
		send_report(4'd1, 1'b1);
		send_report(4'd2, 1'b0);
		send_report(4'd3, 1'b0);
		set_ring(5'd0);
		send_report(4'd0, 1'b0);
		send_report(4'd1, 1'b0);
		send_report(4'd15, 1'b1);
		set_ring(5'd31);
		send_report(4'd15, 1'b0);
		send_report(4'd4, 1'b1);
		// Token now sits at agent 5, beyond a ring of five.
		set_ring(5'd5);
		send_report(4'd5, 1'b0);
		send_report(4'd4, 1'b0);
		set_ring(5'd6);
		send_report(4'd5, 1'b0);
		send_report(4'd0, 1'b0);
		set_ring(5'd1);
		send_report(rtd_pkg::AGENT_W'(holder_idx()), 1'b1);
		send_report(4'd0, 1'b1);
	endtask

	task automatic test_random_ring();
		logic [rtd_pkg::CFG_W-1:0] sizes [8];
		sizes = '{5'd16, 5'd1, 5'd2, 5'd0, 5'd31, 5'd7, 5'd3, 5'd16};
		sizes[7] = rtd_pkg::CFG_W'($urandom_range(1, rtd_pkg::AGENT_SPAN));
		for (int p = 0; p < 8; p++) begin
			enter_ring(sizes[p]);
			if (p == 3) no_idle = 1'b1;
			random_reports(PHASE_ITEMS);
			no_idle = 1'b0;
		end
	endtask

	task automatic test_backpressure();
		enter_ring(5'd16);
		no_idle = 1'b1;
		hold_req = 1'b1;
		random_reports(60);
		no_idle = 1'b0;
	endtask

	// Runs last: termination is sticky until reset.
	task automatic test_termination();
		enter_ring(5'd2);
		while (!ring_done)
			send_report(rtd_pkg::AGENT_W'(holder_idx()), 1'b0);
		send_report(4'd0, 1'b1);
		send_report(4'd0, 1'b0);
		send_report(4'd1, 1'b0);
		send_report(4'd1, 1'b1);
		send_report(4'd2, 1'b0);
		send_report(4'd15, 1'b0);
		send_report(4'd0, 1'b0);
	endtask

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, actual %0d", name, exp_v, act_v);
			errors_seen++;
		end
	endtask

	always @(posedge clk) begin
		rtd_pkg::result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_outcomes.size() == 0) begin
				$error("result word with no report pending");
				errors_seen++;
			end else begin
				exp_r = pending_outcomes.pop_front();
				check_field("terminated", int'(exp_r.terminated), int'(terminated));
				check_field("token_passed", int'(exp_r.token_passed),
					int'(token_passed));
				check_field("token_receiver", int'(exp_r.token_receiver),
					int'(token_receiver));
				check_field("token_black", int'(exp_r.token_black), int'(token_black));
				check_field("error", int'(exp_r.error), int'(error));
			end
		end
	end

	// Receiver side: random stalls, and one long hold-off on request.
	always @(posedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken = 1'b1;
			out_stall <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
		end
		out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 33);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb: errors");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < rtd_pkg::AGENT_SPAN; i++) begin
			tok_held[i] = (i == 0);
			tok_dirty[i] = 1'b0;
			agent_dirty[i] = 1'b1;
		end
		prev_round_clean = 1'b1;
		ring_done = 1'b0;
		ring_size_reg = rtd_pkg::ACTIVE_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_edges();
		test_random_ring();
		test_backpressure();
		test_termination();
		drain();
		repeat (8) @(posedge clk);
		if (errors_seen == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule
